/* hw/rtl/mpc_pkg.sv */
package mpc_pkg;

   localparam int TAG_W        = 31;
   localparam int CNT_W        = 32;
   localparam int SIZE_CFG_W   = 5;
   localparam int OCC_OUT_W    = 5;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = 3;
   localparam int DEF_SLOTS    = 16;

   localparam logic [SIZE_CFG_W-1:0] ACTIVE_SIZE_RESET = 5'd16;
   localparam logic [CNT_W-1:0]      CNT_RESET         = 32'd1;
   localparam logic [CNT_W-1:0]      CNT_MAX           = 32'hFFFF_FFFF;

   // register index, taken from paddr[2]
   localparam logic REG_ACTIVE_SIZE = 1'b0;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_DROP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_CMP   = 2'd1,
      ST_APPLY = 2'd2
   } state_type;

   typedef struct packed {
      logic     cmp_en;
      logic     apply_en;
      logic     trim_en;
      kind_type kind;
   } cell_ctl_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

/* hw/rtl/mpc_cell.sv */
module mpc_cell #(
   parameter int SLOTS  = mpc_pkg::DEF_SLOTS,
   parameter int INDEX  = 0,
   parameter int SIZE_W = $clog2(SLOTS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mpc_pkg::cell_ctl_type    ctl,
   input  logic [SIZE_W-1:0]        eff_size,
   input  logic [mpc_pkg::TAG_W-1:0] op_tag,
   input  logic [mpc_pkg::TAG_W-1:0] prev_tag,
   input  logic                     prev_valid,
   input  logic [mpc_pkg::TAG_W-1:0] next_tag,
   input  logic                     next_valid,
   input  logic                     above_in,
   input  logic                     hit_any,
   output logic                     above_out,
   output logic [mpc_pkg::TAG_W-1:0] tag_out,
   output logic                     valid_out
);

   logic [mpc_pkg::TAG_W-1:0] tag_ff;
   logic                      valid_ff;
   logic                      match_ff;
   logic                      in_size;

   assign in_size   = SIZE_W'(INDEX) < eff_size;
   assign above_out = above_in | match_ff;
   assign tag_out   = tag_ff;
   assign valid_out = valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         match_ff <= valid_ff && (tag_ff == op_tag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.trim_en) begin
         if (!in_size) begin
            valid_ff <= 1'b0;
         end
      end else if (ctl.apply_en) begin
         unique case (ctl.kind)
            mpc_pkg::KIND_LOOKUP: begin
            end
            mpc_pkg::KIND_INSERT: begin
               if (in_size) begin
                  valid_ff <= prev_valid;
               end
            end
            mpc_pkg::KIND_REMOVE: begin
               if (above_out) begin
                  valid_ff <= next_valid;
               end
            end
            mpc_pkg::KIND_DROP: begin
               valid_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.apply_en) begin
         unique case (ctl.kind)
            mpc_pkg::KIND_LOOKUP: begin
               // entries above the hit move down one slot; the hit tag enters at slot 0
               if (hit_any && !above_in) begin
                  tag_ff <= prev_tag;
               end
            end
            mpc_pkg::KIND_INSERT: begin
               if (in_size) begin
                  tag_ff <= prev_tag;
               end
            end
            mpc_pkg::KIND_REMOVE: begin
               if (above_out) begin
                  tag_ff <= next_tag;
               end
            end
            mpc_pkg::KIND_DROP: begin
            end
            default: begin
            end
         endcase
      end
   end

endmodule

/* hw/rtl/mru_page_tag_cache.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_kind, req_page_offset
// rsp       out        rsp_valid/rsp_stall  hit, writeback, counters, occupancy
// csr       in         APB psel/penable     active_size at address 0
//
// A request passes three steps: accept, a compare state in which every cell
// matches its tag, and an apply state in which the cells shift or clear.
// One request is in flight; the next is accepted once the result is registered.
// A result waiting under rsp_stall holds the apply cycle until it is taken.
// Reset empties every slot, sets both counters to one and active_size to 16.
module mru_page_tag_cache #(
   parameter int SLOTS = mpc_pkg::DEF_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_kind,
   input  logic [mpc_pkg::TAG_W-1:0]         req_page_offset,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_writeback_valid,
   output logic [mpc_pkg::TAG_W-1:0]         rsp_writeback_offset,
   output logic [mpc_pkg::CNT_W-1:0]         rsp_hit_count,
   output logic [mpc_pkg::CNT_W-1:0]         rsp_attempt_count,
   output logic [mpc_pkg::OCC_OUT_W-1:0]     rsp_occupancy,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mpc_pkg::ADDR_W-1:0]        paddr,
   input  logic [mpc_pkg::DATA_W-1:0]        pwdata,
   output logic [mpc_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   localparam int SIZE_W = $clog2(SLOTS + 1);
   localparam int IDX_W  = $clog2(SLOTS);

   mpc_pkg::state_type state_ff, state_in;
   mpc_pkg::kind_type  kind_ff;
   logic [mpc_pkg::TAG_W-1:0]      op_tag_ff;
   logic [mpc_pkg::SIZE_CFG_W-1:0] active_size_ff;
   logic                           trim_pend_ff;
   logic [SIZE_W-1:0]              occ_ff, occ_in;
   logic [mpc_pkg::CNT_W-1:0]      hit_total_ff, hit_total_in;
   logic [mpc_pkg::CNT_W-1:0]      attempt_total_ff, attempt_total_in;

   logic                           rsp_valid_ff;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic                           rsp_wb_valid_ff, rsp_wb_valid_in;
   logic [mpc_pkg::TAG_W-1:0]      rsp_wb_offset_ff, rsp_wb_offset_in;
   logic [mpc_pkg::OCC_OUT_W-1:0]  rsp_occ_ff;

   logic [SIZE_W-1:0]              eff_size;
   logic [IDX_W-1:0]               last_idx;
   logic                           req_accept, rsp_accept, csr_write, load_rsp;
   mpc_pkg::cell_ctl_type          ctl;

   logic [mpc_pkg::TAG_W-1:0]      tag_q [SLOTS];
   logic [SLOTS-1:0]               valid_q;
   logic [SLOTS:0]                 above;
   logic                           hit_any;

   assign pready     = 1'b1;
   assign prdata     = mpc_pkg::DATA_W'(active_size_ff);
   assign csr_write  = psel && penable && pwrite && (paddr[2] == mpc_pkg::REG_ACTIVE_SIZE);
   assign req_stall  = (state_ff != mpc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   always_comb begin
      if (active_size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (int'(active_size_ff) > SLOTS) begin
         eff_size = SIZE_W'(SLOTS);
      end else begin
         eff_size = SIZE_W'(active_size_ff);
      end
   end

   assign last_idx = IDX_W'(eff_size - SIZE_W'(1));

   assign ctl.cmp_en   = (state_ff == mpc_pkg::ST_CMP);
   assign ctl.apply_en = load_rsp;
   assign ctl.trim_en  = trim_pend_ff;
   assign ctl.kind     = kind_ff;

   // cell chain
   assign above[0] = 1'b0;
   assign hit_any  = above[SLOTS];

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [mpc_pkg::TAG_W-1:0] prev_tag, next_tag;
      logic                      prev_valid, next_valid;
      if (i == 0) begin : g_first
         assign prev_tag   = op_tag_ff;
         assign prev_valid = 1'b1;
      end else begin : g_mid
         assign prev_tag   = tag_q[i-1];
         assign prev_valid = valid_q[i-1];
      end
      if (i == SLOTS - 1) begin : g_last
         assign next_tag   = '0;
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_tag   = tag_q[i+1];
         assign next_valid = valid_q[i+1];
      end
      mpc_cell #(
         .SLOTS  (SLOTS),
         .INDEX  (i),
         .SIZE_W (SIZE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .eff_size   (eff_size),
         .op_tag     (op_tag_ff),
         .prev_tag   (prev_tag),
         .prev_valid (prev_valid),
         .next_tag   (next_tag),
         .next_valid (next_valid),
         .above_in   (above[i]),
         .hit_any    (hit_any),
         .above_out  (above[i+1]),
         .tag_out    (tag_q[i]),
         .valid_out  (valid_q[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         mpc_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = mpc_pkg::ST_CMP;
            end
         end
         mpc_pkg::ST_CMP: begin
            state_in = mpc_pkg::ST_APPLY;
         end
         mpc_pkg::ST_APPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = mpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      occ_in           = occ_ff;
      hit_total_in     = hit_total_ff;
      attempt_total_in = attempt_total_ff;
      rsp_hit_in       = 1'b0;
      rsp_wb_valid_in  = 1'b0;
      rsp_wb_offset_in = '0;
      unique case (kind_ff)
         mpc_pkg::KIND_LOOKUP: begin
            attempt_total_in = mpc_pkg::sat_inc(attempt_total_ff);
            if (hit_any) begin
               rsp_hit_in   = 1'b1;
               hit_total_in = mpc_pkg::sat_inc(hit_total_ff);
            end
         end
         mpc_pkg::KIND_INSERT: begin
            if (valid_q[last_idx]) begin
               rsp_wb_valid_in  = 1'b1;
               rsp_wb_offset_in = tag_q[last_idx];
            end
            if (occ_ff < eff_size) begin
               occ_in = occ_ff + SIZE_W'(1);
            end
         end
         mpc_pkg::KIND_REMOVE: begin
            if (hit_any) begin
               rsp_wb_valid_in  = 1'b1;
               rsp_wb_offset_in = op_tag_ff;
               occ_in           = occ_ff - SIZE_W'(1);
            end
         end
         mpc_pkg::KIND_DROP: begin
            occ_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mpc_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         active_size_ff   <= mpc_pkg::ACTIVE_SIZE_RESET;
         trim_pend_ff     <= 1'b0;
         occ_ff           <= '0;
         hit_total_ff     <= mpc_pkg::CNT_RESET;
         attempt_total_ff <= mpc_pkg::CNT_RESET;
      end else begin
         state_ff     <= state_in;
         trim_pend_ff <= csr_write;
         if (csr_write) begin
            active_size_ff <= pwdata[mpc_pkg::SIZE_CFG_W-1:0];
         end
         if (trim_pend_ff) begin
            if (occ_ff > eff_size) begin
               occ_ff <= eff_size;
            end
         end else if (load_rsp) begin
            occ_ff           <= occ_in;
            hit_total_ff     <= hit_total_in;
            attempt_total_ff <= attempt_total_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff   <= mpc_pkg::kind_type'(req_kind);
         op_tag_ff <= req_page_offset;
      end
      if (load_rsp) begin
         rsp_hit_ff       <= rsp_hit_in;
         rsp_wb_valid_ff  <= rsp_wb_valid_in;
         rsp_wb_offset_ff <= rsp_wb_offset_in;
         rsp_occ_ff       <= mpc_pkg::OCC_OUT_W'(occ_in);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_writeback_valid  = rsp_wb_valid_ff;
   assign rsp_writeback_offset = rsp_wb_offset_ff;
   assign rsp_hit_count        = hit_total_ff;
   assign rsp_attempt_count    = attempt_total_ff;
   assign rsp_occupancy        = rsp_occ_ff;

   a_req_to_cmp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == mpc_pkg::ST_CMP))
      else $error("accepted request did not enter compare");

   a_hit_le_attempt: assert property (@(posedge clock) disable iff (reset)
      hit_total_ff <= attempt_total_ff)
      else $error("hit count above attempt count");

   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> !rsp_wb_valid_ff)
      else $error("lookup hit reported a writeback");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_q & (valid_q + SLOTS'(1))) == '0)
      else $error("valid slots are not a prefix");

   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      !trim_pend_ff |-> ($countones(valid_q) == int'(occ_ff)))
      else $error("occupancy does not match valid slots");

endmodule

/* tb/sv/tb_mru_page_tag_cache.sv */
`timescale 1ns / 1ps

module tb_mru_page_tag_cache;

   localparam int CACHE_SLOTS    = mpc_pkg::DEF_SLOTS;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 75;

   typedef struct {
      mpc_pkg::kind_type                 kind;
      logic [mpc_pkg::TAG_W-1:0]         offset;
      bit                                wait_drain;
   } cache_req_type;

   typedef struct {
      logic                              hit;
      logic                              wb_valid;
      logic [mpc_pkg::TAG_W-1:0]         wb_offset;
      logic [mpc_pkg::CNT_W-1:0]         hits;
      logic [mpc_pkg::CNT_W-1:0]         attempts;
      logic [mpc_pkg::OCC_OUT_W-1:0]     occupancy;
   } cache_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [1:0]                           req_kind = mpc_pkg::KIND_LOOKUP;
   logic [mpc_pkg::TAG_W-1:0]            req_page_offset = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_hit;
   logic                                 rsp_writeback_valid;
   logic [mpc_pkg::TAG_W-1:0]            rsp_writeback_offset;
   logic [mpc_pkg::CNT_W-1:0]            rsp_hit_count;
   logic [mpc_pkg::CNT_W-1:0]            rsp_attempt_count;
   logic [mpc_pkg::OCC_OUT_W-1:0]        rsp_occupancy;
   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [mpc_pkg::ADDR_W-1:0]           paddr = '0;
   logic [mpc_pkg::DATA_W-1:0]           pwdata = '0;
   logic [mpc_pkg::DATA_W-1:0]           prdata;
   logic                                 pready;

   // cache mirror
   logic [mpc_pkg::TAG_W-1:0]            tag_mirror [CACHE_SLOTS];
   bit                                   valid_mirror [CACHE_SLOTS];
   logic [mpc_pkg::CNT_W-1:0]            hits_mirror;
   logic [mpc_pkg::CNT_W-1:0]            attempts_mirror;
   logic [mpc_pkg::SIZE_CFG_W-1:0]       size_cfg;

   cache_req_type                        pend_q[$];
   cache_result_type                     exp_q[$];
   logic [mpc_pkg::TAG_W-1:0]            tag_pool [24];

   int                                   errors = 0;
   int                                   results_seen = 0;
   int                                   send_gap = 0;
   int                                   stall_left = 0;
   int                                   hold_left = 0;
   int                                   quiet_cycles = 0;
   bit                                   quiet = 1'b0;

   mru_page_tag_cache dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_page_offset      (req_page_offset),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_writeback_valid  (rsp_writeback_valid),
      .rsp_writeback_offset (rsp_writeback_offset),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_attempt_count    (rsp_attempt_count),
      .rsp_occupancy        (rsp_occupancy),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always #5 clock = ~clock;

   function automatic int live_size();
      if (size_cfg == 0) return 1;
      if (size_cfg > CACHE_SLOTS) return CACHE_SLOTS;
      return int'(size_cfg);
   endfunction

   function automatic int live_count();
      int n = 0;
      while (n < CACHE_SLOTS && valid_mirror[n]) n++;
      return n;
   endfunction

   function automatic cache_result_type apply_request(mpc_pkg::kind_type kind,
                                                      logic [mpc_pkg::TAG_W-1:0] offset);
      cache_result_type r;
      int               size_now;
      int               occ;
      int               pos;
      r = '{default: '0};
      size_now = live_size();
      occ = live_count();
      if (occ > size_now) occ = size_now;
      for (pos = 0; pos < occ; pos++) begin
         if (tag_mirror[pos] == offset) break;
      end
      case (kind)
         mpc_pkg::KIND_LOOKUP: begin
            if (attempts_mirror != mpc_pkg::CNT_MAX) attempts_mirror = attempts_mirror + 1;
            if (pos < occ) begin
               r.hit = 1'b1;
               if (hits_mirror != mpc_pkg::CNT_MAX) hits_mirror = hits_mirror + 1;
               for (int j = pos; j > 0; j--) tag_mirror[j] = tag_mirror[j-1];
               tag_mirror[0] = offset;
            end
         end
         mpc_pkg::KIND_INSERT: begin
            if (valid_mirror[size_now-1]) begin
               r.wb_valid = 1'b1;
               r.wb_offset = tag_mirror[size_now-1];
            end
            for (int j = size_now - 1; j > 0; j--) begin
               tag_mirror[j] = tag_mirror[j-1];
               valid_mirror[j] = valid_mirror[j-1];
            end
            tag_mirror[0] = offset;
            valid_mirror[0] = 1'b1;
         end
         mpc_pkg::KIND_REMOVE: begin
            if (pos < occ) begin
               r.wb_valid = 1'b1;
               r.wb_offset = tag_mirror[pos];
               for (int j = pos; j + 1 < occ; j++) tag_mirror[j] = tag_mirror[j+1];
               valid_mirror[occ-1] = 1'b0;
            end
         end
         default: begin
            for (int j = 0; j < CACHE_SLOTS; j++) valid_mirror[j] = 1'b0;
         end
      endcase
      r.hits = hits_mirror;
      r.attempts = attempts_mirror;
      r.occupancy = mpc_pkg::OCC_OUT_W'(live_count());
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic cache_req_type random_request(int pool_n);
      cache_req_type r;
      int            roll;
      roll = $urandom_range(99);
      if (roll < 45) r.kind = mpc_pkg::KIND_LOOKUP;
      else if (roll < 75) r.kind = mpc_pkg::KIND_INSERT;
      else if (roll < 96) r.kind = mpc_pkg::KIND_REMOVE;
      else r.kind = mpc_pkg::KIND_DROP;
      if ($urandom_range(99) < 75) r.offset = tag_pool[$urandom_range(pool_n - 1)];
      else r.offset = mpc_pkg::TAG_W'($urandom);
      r.wait_drain = ($urandom_range(49) == 0);
      return r;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      end
   endfunction

   task automatic queue_request(mpc_pkg::kind_type kind, logic [mpc_pkg::TAG_W-1:0] offset);
      pend_q.push_back('{kind, offset, 1'b0});
   endtask

   task automatic wait_idle();
      while (pend_q.size() != 0 || exp_q.size() != 0 || req_valid) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_active_size(logic [mpc_pkg::SIZE_CFG_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= mpc_pkg::ADDR_W'({mpc_pkg::REG_ACTIVE_SIZE, 2'b00});
      pwdata  <= {27'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      size_cfg = value;
      for (int i = live_size(); i < CACHE_SLOTS; i++) valid_mirror[i] = 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      cache_req_type item;
      logic          next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            exp_q.push_back(apply_request(mpc_pkg::kind_type'(req_kind), req_page_offset));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pend_q.size() != 0 && !(pend_q[0].wait_drain && exp_q.size() != 0)) begin
               item = pend_q.pop_front();
               req_kind        <= item.kind;
               req_page_offset <= item.offset;
               next_valid = 1'b1;
               send_gap = quiet ? 0 : pick_gap();
            end
         end
         req_valid <= next_valid;
      end
   end

   // result monitor
   always @(posedge clock) begin
      cache_result_type want;
      logic             next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (results_seen == 150 || results_seen == 520) hold_left = 200;
            if (exp_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual hit %b wb %b %h occ %0d",
                        $time, rsp_hit, rsp_writeback_valid, rsp_writeback_offset, rsp_occupancy);
            end else begin
               want = exp_q.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("writeback_valid", 32'(want.wb_valid), 32'(rsp_writeback_valid));
               check_field("writeback_offset", 32'(want.wb_offset), 32'(rsp_writeback_offset));
               check_field("hit_count", want.hits, rsp_hit_count);
               check_field("attempt_count", want.attempts, rsp_attempt_count);
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (quiet || $urandom_range(99) < 55) begin
            next_stall = 1'b0;
         end else begin
            next_stall = 1'b1;
            stall_left = pick_gap();
         end
         rsp_stall <= next_stall;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [mpc_pkg::SIZE_CFG_W-1:0] phase_size [PHASE_COUNT];
      int                             pool_n;
      phase_size = '{5'd1, 5'd2, 5'd0, 5'd16, 5'd31, 5'd4, 5'd17, 5'd8, 5'd3, 5'd12};
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         tag_mirror[i] = '0;
         valid_mirror[i] = 1'b0;
      end
      hits_mirror = mpc_pkg::CNT_RESET;
      attempts_mirror = mpc_pkg::CNT_RESET;
      size_cfg = mpc_pkg::ACTIVE_SIZE_RESET;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 24; i++) tag_pool[i] = mpc_pkg::TAG_W'($urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      queue_request(mpc_pkg::KIND_LOOKUP, '0);
      queue_request(mpc_pkg::KIND_REMOVE, 31'd5);
      queue_request(mpc_pkg::KIND_INSERT, '0);
      queue_request(mpc_pkg::KIND_INSERT, '1);
      queue_request(mpc_pkg::KIND_INSERT, 31'h5555_5555);
      queue_request(mpc_pkg::KIND_INSERT, 31'h2AAA_AAAA);
      queue_request(mpc_pkg::KIND_LOOKUP, '0);
      queue_request(mpc_pkg::KIND_LOOKUP, '1);
      queue_request(mpc_pkg::KIND_LOOKUP, 31'h1234);
      queue_request(mpc_pkg::KIND_REMOVE, 31'h1234);
      queue_request(mpc_pkg::KIND_REMOVE, 31'h5555_5555);
      queue_request(mpc_pkg::KIND_INSERT, 31'h1234_5678);
      queue_request(mpc_pkg::KIND_INSERT, 31'h1234_5678);
      queue_request(mpc_pkg::KIND_LOOKUP, 31'h1234_5678);
      queue_request(mpc_pkg::KIND_REMOVE, 31'h1234_5678);
      queue_request(mpc_pkg::KIND_LOOKUP, 31'h1234_5678);
      queue_request(mpc_pkg::KIND_DROP, 31'h2AAA_AAAA);
      queue_request(mpc_pkg::KIND_LOOKUP, '0);
      queue_request(mpc_pkg::KIND_INSERT, '1);
      queue_request(mpc_pkg::KIND_DROP, '1);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         set_active_size(phase_size[p]);
         quiet = (p == 3 || p == 7);
         pool_n = $urandom_range(20, 3);
         for (int k = 0; k < PHASE_ITEMS; k++) pend_q.push_back(random_request(pool_n));
      end
      wait_idle();

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mpc_pkg.sv
hw/rtl/mpc_cell.sv
hw/rtl/mru_page_tag_cache.sv
tb/sv/tb_mru_page_tag_cache.sv
